// File: rtl/smfr_pkg.sv
// Shared constants, types and helpers for the start-marker frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package smfr_pkg;

    // marker letters
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_R = 8'h52;

    localparam int COUNT_W = 7;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 4;

    localparam logic [COUNT_W-1:0] EXPECTED_WORDS_RESET = 7'd2;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_HUNT    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_GOT_S   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_GOT_T   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_GOT_A   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_GOT_R   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_W0_LO   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_W0_HI   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_W1_LO   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_W1_HI   = 4'd10;

    // one finished-frame result word
    typedef struct packed {
        logic [COUNT_W-1:0] word_count;
        logic               values_taken;
        logic [BYTE_W-1:0]  state_value;
        logic [BYTE_W-1:0]  command_value;
    } smfr_result_t;

    // letter expected in a given marker phase; the last T follows R
    function automatic logic [BYTE_W-1:0] marker_want(input logic [PHASE_W-1:0] ph);
        logic [BYTE_W-1:0] want;
        case (ph)
            PH_HUNT:  want = CH_S;
            PH_GOT_S: want = CH_T;
            PH_GOT_T: want = CH_A;
            PH_GOT_A: want = CH_R;
            PH_GOT_R: want = CH_T;
            default:  want = CH_S;
        endcase
        return want;
    endfunction

    // marker search step: a stray S restarts at the second letter
    function automatic logic [PHASE_W-1:0] marker_next(input logic [PHASE_W-1:0] ph,
                                                       input logic [BYTE_W-1:0] b);
        logic [PHASE_W-1:0] nxt;
        if (b == marker_want(ph)) begin
            nxt = ph + 4'd1;
        end else if (b == CH_S) begin
            nxt = PH_GOT_S;
        end else begin
            nxt = PH_HUNT;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: rtl/smfr_parser.sv
// Frame parser: phase tracking, announced count and held payload bytes.
// Depends on smfr_pkg; takes one byte per cycle when step is high.
`default_nettype none

module smfr_parser
    import smfr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic [BYTE_W-1:0]  rx_byte,
    input  wire logic [COUNT_W-1:0] expected_words,
    output logic                    res_valid,
    output smfr_result_t            res
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  first_reg, first_next;
    logic [BYTE_W-1:0]  second_reg, second_next;

    // next state and frame-end detection for the byte at hand
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        res_valid   = 1'b0;
        res.values_taken = 1'b0;
        case (phase_reg)
            PH_HUNT, PH_GOT_S, PH_GOT_T, PH_GOT_A, PH_GOT_R: begin
                phase_next = marker_next(phase_reg, rx_byte);
            end
            PH_LEN_LO: begin
                count_next = rx_byte[BYTE_W-1:1];
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if (count_reg == expected_words) begin
                    phase_next = PH_W0_LO;
                end else begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                end
            end
            PH_W0_LO: begin
                first_next = rx_byte;
                phase_next = PH_W0_HI;
            end
            PH_W0_HI: begin
                phase_next = PH_W1_LO;
            end
            PH_W1_LO: begin
                second_next = rx_byte;
                phase_next  = PH_W1_HI;
            end
            PH_W1_HI: begin
                phase_next       = PH_HUNT;
                res_valid        = 1'b1;
                res.values_taken = 1'b1;
            end
            default: begin
                phase_next = marker_next(PH_HUNT, rx_byte);
            end
        endcase
        res.word_count    = count_reg;
        res.state_value   = first_reg;
        res.command_value = second_reg;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

`ifndef SYNTHESIS
    // a frame end always returns to the hunt
    a_end_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid |=> phase_reg == PH_HUNT)
        else $error("phase did not return to hunt after frame end");

    // unused phase codes are never entered
    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_W1_HI)
        else $error("phase left the legal range");

    // captured frames end on the last payload byte, others on the length high byte
    a_result_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.values_taken ? (phase_reg == PH_W1_HI)
                                        : (phase_reg == PH_LEN_HI)))
        else $error("frame result from an unexpected phase");
`endif

endmodule

`default_nettype wire

// File: rtl/smfr_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on smfr_pkg for the result type.
`default_nettype none

module smfr_out_reg
    import smfr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire smfr_result_t load_data,
    output logic              free,
    output logic              m_valid,
    input  wire logic         m_ready,
    output smfr_result_t      m_data
);

    logic         valid_reg;
    smfr_result_t data_reg;

    // room for a new result when empty or draining this cycle
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/start_marker_frame_receiver_core.sv
// Start-marker frame receiver: one received byte in at a time, one result per frame.
// Each accepted byte is held in the input register; a frame result is then loaded
// into the result register. One byte is taken every cycle, set by the single
// registered pass through the phase logic, as long as the result register drains.
// A byte that ends a frame waits in the input register while an earlier result is
// still unread. Depends on smfr_pkg, smfr_parser and smfr_out_reg.
`default_nettype none

module start_marker_frame_receiver_core
    import smfr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // received bytes
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [BYTE_W-1:0]  s_rx_byte,
    // frame results
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COUNT_W-1:0]      m_word_count,
    output logic                    m_values_taken,
    output logic [BYTE_W-1:0]       m_state_value,
    output logic [BYTE_W-1:0]       m_command_value,
    // expected word count register
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_expected_words
);

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic [COUNT_W-1:0] expected_reg;
    logic               step;
    logic               res_valid;
    logic               out_free;
    smfr_result_t       res;
    smfr_result_t       out_data;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= EXPECTED_WORDS_RESET;
        end else if (cfg_valid) begin
            expected_reg <= cfg_expected_words;
        end
    end

    // held byte moves on unless it ends a frame and the result slot is full
    assign step    = in_valid_reg && (!res_valid || out_free);
    assign s_ready = !in_valid_reg || step;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    smfr_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .rx_byte        (in_byte_reg),
        .expected_words (expected_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    smfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && res_valid),
        .load_data (res),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data)
    );

    assign m_word_count    = out_data.word_count;
    assign m_values_taken  = out_data.values_taken;
    assign m_state_value   = out_data.state_value;
    assign m_command_value = out_data.command_value;

endmodule

`default_nettype wire
